// ===== src/tdpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types for the trial division prime test unit: sequencer states.
// ----------------------------------------------------------------------------
package tdpt_pkg;

   // sequencer states of the top level
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV3,
      ST_TRY_LO,
      ST_TRY_HI,
      ST_FINISH
   } state_type;

endpackage

// ===== src/tdpt_req_if.sv =====
// ----------------------------------------------------------------------------
// tdpt_req_if
// Request channel: one candidate word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tdpt_req_if #(
   parameter int VALUE_BITS = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] candidate;

   modport source (output valid, output candidate, input ready);
   modport sink   (input valid, input candidate, output ready);
endinterface

// ===== src/tdpt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tdpt_rsp_if
// Response channel: one prime flag word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tdpt_rsp_if;
   logic valid;
   logic ready;
   logic is_prime;

   modport source (output valid, output is_prime, input ready);
   modport sink   (input valid, input is_prime, output ready);
endinterface

// ===== src/trial_division_prime_test_unit.sv =====
// Values settled without division need no divider; otherwise the shared
// radix-2 divider does one division for the test by 3 and two per divisor
// pair 6k-1, 6k+1 up to the square root, about 7700 pairs at worst for
// VALUE_BITS = 32.
// One word at a time; a finished result may wait while the next is taken.
// Reset is synchronous, active high, and returns the block to idle.
// ----------------------------------------------------------------------------
// trial_division_prime_test_unit
// Decides primality of a signed candidate by trial division by 3 and the 6k+/-1
// divisors, sharing one iterative divider for every remainder and bound test.
// ----------------------------------------------------------------------------
module trial_division_prime_test_unit #(
   parameter int VALUE_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   tdpt_req_if.sink   req_chan,
   tdpt_rsp_if.source rsp_chan
);

   localparam int DIV_BITS = VALUE_BITS - 1;

   tdpt_pkg::state_type state_ff, state_in;

   logic [DIV_BITS-1:0] n_ff,      n_in;
   logic                sign_ff,   sign_in;
   logic [DIV_BITS-1:0] d_ff,      d_in;
   logic                result_ff, result_in;
   logic                rsp_valid_ff;
   logic                rsp_prime_ff;

   logic                req_accept;
   logic                slot_free;
   logic                div_start;
   logic [DIV_BITS-1:0] div_divisor;
   logic                div_done;
   logic [DIV_BITS-1:0] div_quotient;
   logic [DIV_BITS-1:0] div_remainder;
   logic                rem_zero;
   logic                trivial;
   logic                past_root;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign slot_free  = !rsp_valid_ff || rsp_chan.ready;
   assign rem_zero   = div_remainder == '0;
   assign past_root  = d_ff > div_quotient;

   // values settled without division: non-positive, one, two, three, even
   assign trivial = sign_ff || (n_ff <= DIV_BITS'(3)) || !n_ff[0];

   // shared divider
   tdpt_divider #(
      .DIV_BITS (DIV_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (n_ff),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tdpt_pkg::ST_IDLE: begin
            if (req_accept) state_in = tdpt_pkg::ST_CHECK;
         end
         tdpt_pkg::ST_CHECK: begin
            state_in = trivial ? tdpt_pkg::ST_FINISH : tdpt_pkg::ST_DIV3;
         end
         tdpt_pkg::ST_DIV3: begin
            if (div_done) state_in = rem_zero ? tdpt_pkg::ST_FINISH : tdpt_pkg::ST_TRY_LO;
         end
         tdpt_pkg::ST_TRY_LO: begin
            if (div_done) begin
               state_in = (past_root || rem_zero) ? tdpt_pkg::ST_FINISH
                                                  : tdpt_pkg::ST_TRY_HI;
            end
         end
         tdpt_pkg::ST_TRY_HI: begin
            if (div_done) state_in = rem_zero ? tdpt_pkg::ST_FINISH : tdpt_pkg::ST_TRY_LO;
         end
         tdpt_pkg::ST_FINISH: begin
            if (slot_free) state_in = tdpt_pkg::ST_IDLE;
         end
         default: state_in = tdpt_pkg::ST_IDLE;
      endcase
   end

   // datapath control and divider requests
   always_comb begin
      n_in        = n_ff;
      sign_in     = sign_ff;
      d_in        = d_ff;
      result_in   = result_ff;
      div_start   = 1'b0;
      div_divisor = d_ff;
      unique case (state_ff)
         tdpt_pkg::ST_IDLE: begin
            if (req_accept) begin
               n_in    = req_chan.candidate[DIV_BITS-1:0];
               sign_in = req_chan.candidate[VALUE_BITS-1];
            end
         end
         tdpt_pkg::ST_CHECK: begin
            // two and three are prime, the rest of the trivial set is not
            result_in = !sign_ff && (n_ff > DIV_BITS'(1)) && (n_ff <= DIV_BITS'(3));
            if (!trivial) begin
               div_start   = 1'b1;
               div_divisor = DIV_BITS'(3);
            end
         end
         tdpt_pkg::ST_DIV3: begin
            result_in = 1'b0;
            if (div_done && !rem_zero) begin
               div_start   = 1'b1;
               div_divisor = DIV_BITS'(5);
               d_in        = DIV_BITS'(5);
            end
         end
         tdpt_pkg::ST_TRY_LO: begin
            // divisor beyond the square root means no factor was found
            if (div_done) begin
               result_in = past_root;
               if (!past_root && !rem_zero) begin
                  div_start   = 1'b1;
                  div_divisor = d_ff + DIV_BITS'(2);
               end
            end
         end
         tdpt_pkg::ST_TRY_HI: begin
            result_in = 1'b0;
            if (div_done && !rem_zero) begin
               div_start   = 1'b1;
               div_divisor = d_ff + DIV_BITS'(6);
               d_in        = d_ff + DIV_BITS'(6);
            end
         end
         tdpt_pkg::ST_FINISH: begin
            result_in = result_ff;
         end
         default: begin
            result_in = result_ff;
         end
      endcase
   end

   // control registers and response valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tdpt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == tdpt_pkg::ST_FINISH && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      sign_ff   <= sign_in;
      d_ff      <= d_in;
      result_ff <= result_in;
      if (state_ff == tdpt_pkg::ST_FINISH && slot_free) begin
         rsp_prime_ff <= result_ff;
      end
   end

   assign req_chan.ready    = state_ff == tdpt_pkg::ST_IDLE;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.is_prime = rsp_prime_ff;

endmodule

// ===== src/tdpt_divider.sv =====
// ----------------------------------------------------------------------------
// tdpt_divider
// Restoring radix-2 divider, one quotient bit per cycle. Gives quotient and
// remainder with a one-cycle done pulse; a new start is taken on that cycle.
// ----------------------------------------------------------------------------
module tdpt_divider #(
   parameter int DIV_BITS = 31
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DIV_BITS-1:0] dividend,
   input  logic [DIV_BITS-1:0] divisor,
   output logic                done,
   output logic [DIV_BITS-1:0] quotient,
   output logic [DIV_BITS-1:0] remainder
);

   localparam int CNT_BITS = $clog2(DIV_BITS);

   logic                busy_ff,  busy_in;
   logic                done_ff,  done_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [DIV_BITS-1:0] quo_ff,   quo_in;
   logic [DIV_BITS-1:0] rem_ff,   rem_in;
   logic [DIV_BITS-1:0] dsr_ff,   dsr_in;

   logic [DIV_BITS:0]   trial;
   logic [DIV_BITS:0]   diff;
   logic                fits;

   // one shift-subtract step
   always_comb begin
      trial = {rem_ff, quo_ff[DIV_BITS-1]};
      diff  = trial - {1'b0, dsr_ff};
      fits  = trial >= {1'b0, dsr_ff};
   end

   // step control
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_BITS'(DIV_BITS - 1);
         quo_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_BITS-2:0], fits};
         rem_in = fits ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
